// File: rtl/core/rad_pkg.sv
// Shared widths and constants for the rotary axis distance unit.
package rad_pkg;

   localparam int COORD_W           = 32;
   localparam int ANGLE_W           = 16;
   localparam int CSR_W             = 24;
   localparam int CSR_FRAC_BITS     = 16;
   localparam int DIST_W            = 34;
   localparam int POS_FRAC_BITS_DEF = 16;
   localparam int TURN_BITS_DEF     = 16;

   // sum of four squares of values below 2^COORD_W, and its root
   localparam int SUM_W  = 2 * COORD_W + 2;
   localparam int ROOT_W = COORD_W + 1;

   // 4*pi mm per turn in Q8.16
   localparam logic [CSR_W-1:0] MM_PER_TURN_RESET = 24'd823550;

endpackage

// File: rtl/core/rad_diff.sv
// Axis differences, rotary wrap and rotary scaling: three pipeline stages.
module rad_diff #(
   parameter int POS_FRAC_BITS = rad_pkg::POS_FRAC_BITS_DEF,
   parameter int TURN_BITS     = rad_pkg::TURN_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [rad_pkg::COORD_W-1:0]    a_x,
   input  logic signed [rad_pkg::COORD_W-1:0]    a_y,
   input  logic signed [rad_pkg::COORD_W-1:0]    a_z,
   input  logic        [rad_pkg::ANGLE_W-1:0]    a_c,
   input  logic signed [rad_pkg::COORD_W-1:0]    b_x,
   input  logic signed [rad_pkg::COORD_W-1:0]    b_y,
   input  logic signed [rad_pkg::COORD_W-1:0]    b_z,
   input  logic        [rad_pkg::ANGLE_W-1:0]    b_c,
   input  logic        [rad_pkg::CSR_W-1:0]      mm_per_turn,
   output logic                                  out_valid,
   output logic        [rad_pkg::COORD_W-1:0]    out_dx,
   output logic        [rad_pkg::COORD_W-1:0]    out_dy,
   output logic        [rad_pkg::COORD_W-1:0]    out_dz,
   output logic        [rad_pkg::COORD_W-1:0]    out_dc
);

   localparam int CW     = rad_pkg::COORD_W;
   localparam int EXT_W  = rad_pkg::ANGLE_W + TURN_BITS;
   localparam int PROD_W = TURN_BITS + rad_pkg::CSR_W;
   localparam int SHIFT  = TURN_BITS + rad_pkg::CSR_FRAC_BITS - POS_FRAC_BITS;
   localparam int DC_W   = POS_FRAC_BITS + rad_pkg::CSR_W - rad_pkg::CSR_FRAC_BITS - 1;
   localparam logic [TURN_BITS-1:0] HALF = {1'b1, {(TURN_BITS-1){1'b0}}};

   function automatic logic [CW-1:0] magnitude(input logic [CW:0] d);
      logic [CW:0] m;
      m = d[CW] ? (~d + 1'b1) : d;
      return m[CW-1:0];
   endfunction

   // stage 1: signed differences and raw angle difference
   logic                 v1_ff, v1_in;
   logic [CW:0]          sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [TURN_BITS-1:0] dt_ff, dt_in;
   logic [EXT_W-1:0]     ac_ext, bc_ext;

   // stage 2: magnitudes and shortest-turn angle
   logic                 v2_ff, v2_in;
   logic [CW-1:0]        dx2_ff, dx2_in, dy2_ff, dy2_in, dz2_ff, dz2_in;
   logic [TURN_BITS-1:0] tmag_ff, tmag_in;

   // stage 3: angle scaled to millimetres
   logic                 v3_ff, v3_in;
   logic [CW-1:0]        dx3_ff, dx3_in, dy3_ff, dy3_in, dz3_ff, dz3_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   always_comb begin
      ac_ext = {{TURN_BITS{1'b0}}, a_c};
      bc_ext = {{TURN_BITS{1'b0}}, b_c};
      v1_in  = in_valid;
      sx_in  = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
      sy_in  = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
      sz_in  = {b_z[CW-1], b_z} - {a_z[CW-1], a_z};
      dt_in  = bc_ext[TURN_BITS-1:0] - ac_ext[TURN_BITS-1:0];

      v2_in   = v1_ff;
      dx2_in  = magnitude(sx_ff);
      dy2_in  = magnitude(sy_ff);
      dz2_in  = magnitude(sz_ff);
      // an exact half turn keeps its positive sense
      tmag_in = (dt_ff > HALF) ? ({TURN_BITS{1'b0}} - dt_ff) : dt_ff;

      v3_in   = v2_ff;
      dx3_in  = dx2_ff;
      dy3_in  = dy2_ff;
      dz3_in  = dz2_ff;
      prod_in = {{rad_pkg::CSR_W{1'b0}}, tmag_ff} * {{TURN_BITS{1'b0}}, mm_per_turn};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      sz_ff   <= sz_in;
      dt_ff   <= dt_in;
      dx2_ff  <= dx2_in;
      dy2_ff  <= dy2_in;
      dz2_ff  <= dz2_in;
      tmag_ff <= tmag_in;
      dx3_ff  <= dx3_in;
      dy3_ff  <= dy3_in;
      dz3_ff  <= dz3_in;
      prod_ff <= prod_in;
   end

   assign out_valid = v3_ff;
   assign out_dx    = dx3_ff;
   assign out_dy    = dy3_ff;
   assign out_dz    = dz3_ff;
   // truncation toward zero is a plain drop of the low bits: the product is positive
   assign out_dc    = {{(CW-DC_W){1'b0}}, prod_ff[SHIFT +: DC_W]};

`ifndef SYNTH
   a_tmag_half: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (tmag_ff <= HALF))
      else $error("rotary magnitude beyond half a turn");
`endif

endmodule

// File: rtl/core/rad_square.sv
// Squares of the four axis distances and their sum: three pipeline stages.
module rad_square (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [rad_pkg::COORD_W-1:0]     in_dx,
   input  logic [rad_pkg::COORD_W-1:0]     in_dy,
   input  logic [rad_pkg::COORD_W-1:0]     in_dz,
   input  logic [rad_pkg::COORD_W-1:0]     in_dc,
   output logic                            out_valid,
   output logic [rad_pkg::SUM_W-1:0]       out_sum
);

   localparam int SQ_W = 2 * rad_pkg::COORD_W;

   logic            v4_ff, v4_in, v5_ff, v5_in, v6_ff, v6_in;
   logic [SQ_W-1:0] sq_ff [4];
   logic [SQ_W-1:0] sq_in [4];
   logic [SQ_W:0]   pair_ff [2];
   logic [SQ_W:0]   pair_in [2];
   logic [rad_pkg::SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      v4_in    = in_valid;
      sq_in[0] = {{rad_pkg::COORD_W{1'b0}}, in_dx} * {{rad_pkg::COORD_W{1'b0}}, in_dx};
      sq_in[1] = {{rad_pkg::COORD_W{1'b0}}, in_dy} * {{rad_pkg::COORD_W{1'b0}}, in_dy};
      sq_in[2] = {{rad_pkg::COORD_W{1'b0}}, in_dz} * {{rad_pkg::COORD_W{1'b0}}, in_dz};
      sq_in[3] = {{rad_pkg::COORD_W{1'b0}}, in_dc} * {{rad_pkg::COORD_W{1'b0}}, in_dc};

      v5_in      = v4_ff;
      pair_in[0] = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      pair_in[1] = {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};

      v6_in  = v5_ff;
      sum_in = {1'b0, pair_ff[0]} + {1'b0, pair_ff[1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
      for (int i = 0; i < 4; i++) begin
         sq_ff[i] <= sq_in[i];
      end
      for (int i = 0; i < 2; i++) begin
         pair_ff[i] <= pair_in[i];
      end
      sum_ff <= sum_in;
   end

   assign out_valid = v6_ff;
   assign out_sum   = sum_ff;

endmodule

// File: rtl/core/rad_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rad_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rad_pkg::SUM_W-1:0]     in_sum,
   output logic                          out_valid,
   output logic [rad_pkg::ROOT_W-1:0]    out_root
);

   localparam int SW = rad_pkg::SUM_W;
   localparam int RW = rad_pkg::ROOT_W;

   logic          valid_ff [RW];
   logic          valid_in [RW];
   logic [SW-1:0] rem_ff   [RW];
   logic [SW-1:0] rem_in   [RW];
   logic [RW-1:0] root_ff  [RW];
   logic [RW-1:0] root_in  [RW];

   logic          valid_src [RW];
   logic [SW-1:0] rem_src   [RW];
   logic [RW-1:0] root_src  [RW];
   logic [SW:0]   trial     [RW];
   logic          take      [RW];

   // stage k settles root bit RW-1-k; rem holds sum minus root squared
   always_comb begin
      valid_src[0] = in_valid;
      rem_src[0]   = in_sum;
      root_src[0]  = {RW{1'b0}};
      for (int k = 1; k < RW; k++) begin
         valid_src[k] = valid_ff[k-1];
         rem_src[k]   = rem_ff[k-1];
         root_src[k]  = root_ff[k-1];
      end
      for (int k = 0; k < RW; k++) begin
         trial[k]    = ({{(SW+1-RW){1'b0}}, root_src[k]} << (RW - k))
                       | ((SW+1)'(1) << (2 * (RW - 1 - k)));
         take[k]     = ({1'b0, rem_src[k]} >= trial[k]);
         valid_in[k] = valid_src[k];
         rem_in[k]   = take[k] ? (rem_src[k] - trial[k][SW-1:0]) : rem_src[k];
         root_in[k]  = take[k] ? (root_src[k] | (RW'(1) << (RW - 1 - k))) : root_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RW; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < RW; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
      for (int k = 0; k < RW; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];

`ifndef SYNTH
   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (valid_ff[0] == $past(in_valid)))
      else $error("root pipeline dropped or invented a transfer");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[RW-1] |-> (rem_ff[RW-1] <= {{(SW-RW-1){1'b0}}, root_ff[RW-1], 1'b0}))
      else $error("root is not the floor of the square root");
`endif

endmodule

// File: rtl/core/rotary_axis_distance_unit.sv
// Top level of the rotary axis distance unit: rotary register and pipeline.
//
// Gives the floor of the four-axis move length between two tool positions, one result per
// transfer, in unsigned Q18.16 mm. A transfer is taken whenever start is high; busy is
// always low and a new pair may arrive every cycle. Each result appears on rsp_distance for
// one cycle with rsp_valid, in order; the receiver cannot stall it. The pipeline holds three
// stages of difference and rotary scaling, three of squaring and summing, and the square
// root, which settles one result bit per stage over 33 stages. csr_wdata (Q8.16 mm per turn,
// reset 4*pi) is written on csr_we and must only change while no transfer is in flight.
module rotary_axis_distance_unit #(
   parameter int POS_FRAC_BITS = rad_pkg::POS_FRAC_BITS_DEF,
   parameter int TURN_BITS     = rad_pkg::TURN_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [rad_pkg::COORD_W-1:0]    req_a_x,
   input  logic signed [rad_pkg::COORD_W-1:0]    req_a_y,
   input  logic signed [rad_pkg::COORD_W-1:0]    req_a_z,
   input  logic        [rad_pkg::ANGLE_W-1:0]    req_a_c,
   input  logic signed [rad_pkg::COORD_W-1:0]    req_b_x,
   input  logic signed [rad_pkg::COORD_W-1:0]    req_b_y,
   input  logic signed [rad_pkg::COORD_W-1:0]    req_b_z,
   input  logic        [rad_pkg::ANGLE_W-1:0]    req_b_c,
   input  logic                                  csr_we,
   input  logic        [rad_pkg::CSR_W-1:0]      csr_wdata,
   output logic                                  rsp_valid,
   output logic        [rad_pkg::DIST_W-1:0]     rsp_distance
);

   localparam int CW = rad_pkg::COORD_W;
   localparam int RW = rad_pkg::ROOT_W;

   logic [rad_pkg::CSR_W-1:0] mm_per_turn_ff, mm_per_turn_in;
   logic                      accept;

   logic                      diff_valid;
   logic [CW-1:0]             diff_dx, diff_dy, diff_dz, diff_dc;
   logic                      sum_valid;
   logic [rad_pkg::SUM_W-1:0] sum_value;
   logic                      root_valid;
   logic [RW-1:0]             root_value;

   assign busy           = 1'b0;
   assign accept         = start & ~busy;
   assign mm_per_turn_in = csr_we ? csr_wdata : mm_per_turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_per_turn_ff <= rad_pkg::MM_PER_TURN_RESET;
      end else begin
         mm_per_turn_ff <= mm_per_turn_in;
      end
   end

   rad_diff #(
      .POS_FRAC_BITS (POS_FRAC_BITS),
      .TURN_BITS     (TURN_BITS)
   ) u_diff (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .a_x         (req_a_x),
      .a_y         (req_a_y),
      .a_z         (req_a_z),
      .a_c         (req_a_c),
      .b_x         (req_b_x),
      .b_y         (req_b_y),
      .b_z         (req_b_z),
      .b_c         (req_b_c),
      .mm_per_turn (mm_per_turn_ff),
      .out_valid   (diff_valid),
      .out_dx      (diff_dx),
      .out_dy      (diff_dy),
      .out_dz      (diff_dz),
      .out_dc      (diff_dc)
   );

   rad_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_dx     (diff_dx),
      .in_dy     (diff_dy),
      .in_dz     (diff_dz),
      .in_dc     (diff_dc),
      .out_valid (sum_valid),
      .out_sum   (sum_value)
   );

   rad_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_sum    (sum_value),
      .out_valid (root_valid),
      .out_root  (root_value)
   );

   // the root of a sum of four squares below 2^64 never reaches 2^33: no saturation needed
   assign rsp_valid    = root_valid;
   assign rsp_distance = {{(rad_pkg::DIST_W-RW){1'b0}}, root_value};

`ifndef SYNTH
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(csr_we)) |-> (mm_per_turn_ff == $past(csr_wdata)))
      else $error("rotary register missed a write");
`endif

endmodule
